FILE: hdl/qdnm_pkg.sv
// Shared types and constants for the quantize / dequantize nonzero-map block.
`timescale 1ns / 1ps
`default_nettype none

package qdnm_pkg;

    // Fixed field widths of the stream.
    localparam int COEF_W     = 16;
    localparam int MAP_W      = 64;
    localparam int SCALE_W    = 16;
    localparam int ROUND_W    = 30;
    localparam int SHIFT_W    = 5;
    localparam int CFG_DATA_W = 30;
    localparam int CFG_IDX_W  = 3;

    // Magnitude of a coefficient needs one bit more than the coefficient.
    localparam int MAG_W  = COEF_W + 1;
    // Forward product and its rounded sum.
    localparam int PROD_W = MAG_W + SCALE_W;
    localparam int QSUM_W = PROD_W + 1;

    // Depth of the queue between front and back.
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_PTR_W = 2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_QUANT_SCALE   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_QUANT_ROUND   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_QUANT_SHIFT   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_DEQUANT_SCALE = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_DEQUANT_ROUND = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_DEQUANT_SHIFT = 3'd5;

    // One input beat.
    typedef struct packed {
        logic signed [COEF_W-1:0] coefficient;
        logic                     group_end;
        logic                     block_end;
    } coef_beat_t;

    // One result beat.
    typedef struct packed {
        logic signed [COEF_W-1:0] level;
        logic signed [COEF_W-1:0] recon;
        logic                     group_nonzero;
        logic                     group_done;
        logic                     block_done;
        logic [MAP_W-1:0]         nonzero_map;
    } res_beat_t;

    // Configuration register file.
    typedef struct packed {
        logic [SCALE_W-1:0] quant_scale;
        logic [ROUND_W-1:0] quant_round;
        logic [SHIFT_W-1:0] quant_shift;
        logic [SCALE_W-1:0] dequant_scale;
        logic [ROUND_W-1:0] dequant_round;
        logic [SHIFT_W-1:0] dequant_shift;
    } cfg_regs_t;

    // Classified item handed from front to back through the queue.
    typedef struct packed {
        logic [PROD_W-1:0] prod;
        logic              neg;
        logic              group_end;
        logic              block_end;
    } fb_item_t;

endpackage : qdnm_pkg

`default_nettype wire

FILE: hdl/qdnm_front.sv
// Front part: accepts coefficients, splits off the sign and forms the forward product.
`timescale 1ns / 1ps
`default_nettype none

module qdnm_front
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire qdnm_pkg::cfg_regs_t  cfg,
    input  wire logic                 coef_valid,
    output logic                      coef_stall,
    input  wire qdnm_pkg::coef_beat_t coef_data,
    output logic                      item_valid,
    input  wire logic                 item_stall,
    output qdnm_pkg::fb_item_t        item_data
);
    import qdnm_pkg::*;

    logic             valid_reg;
    logic             valid_next;
    fb_item_t         data_reg;
    logic             advance;
    logic             neg;
    logic [MAG_W-1:0] coef_ext;
    logic [MAG_W-1:0] mag;

    // The stage moves when it is empty or its beat leaves for the queue.
    assign advance    = !valid_reg || !item_stall;
    assign coef_stall = !advance;

    // Sign and magnitude; the most negative code gives a full 17-bit magnitude.
    assign neg      = coef_data.coefficient[COEF_W-1];
    assign coef_ext = {coef_data.coefficient[COEF_W-1], coef_data.coefficient};
    assign mag      = neg ? (~coef_ext + MAG_W'(1)) : coef_ext;

    always_comb
    begin
        valid_next = valid_reg;
        if (advance)
        begin
            valid_next = coef_valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Forward product register.
    always_ff @(posedge clk)
    begin
        if (advance && coef_valid)
        begin
            data_reg.prod      <= mag * cfg.quant_scale;
            data_reg.neg       <= neg;
            data_reg.group_end <= coef_data.group_end;
            data_reg.block_end <= coef_data.block_end;
        end
    end

    assign item_valid = valid_reg;
    assign item_data  = data_reg;

endmodule : qdnm_front

`default_nettype wire

FILE: hdl/qdnm_queue.sv
// Short queue that decouples the front part from the back part.
`timescale 1ns / 1ps
`default_nettype none

module qdnm_queue
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               push_valid,
    output logic                    push_stall,
    input  wire qdnm_pkg::fb_item_t push_data,
    output logic                    pop_valid,
    input  wire logic               pop_stall,
    output qdnm_pkg::fb_item_t      pop_data
);
    import qdnm_pkg::*;

    fb_item_t               mem [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0] wr_ptr_reg;
    logic [QUEUE_PTR_W-1:0] rd_ptr_reg;
    logic [QUEUE_PTR_W:0]   count_reg;
    logic [QUEUE_PTR_W:0]   count_next;
    logic                   push;
    logic                   pop;

    assign push_stall = (count_reg == (QUEUE_PTR_W + 1)'(QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign push       = push_valid && !push_stall;
    assign pop        = pop_valid && !pop_stall;
    assign pop_data   = mem[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + (QUEUE_PTR_W + 1)'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - (QUEUE_PTR_W + 1)'(1);
        end
    end

    // Pointers and fill level.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + QUEUE_PTR_W'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + QUEUE_PTR_W'(1);
            end
            count_reg <= count_next;
        end
    end

    // Storage.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

endmodule : qdnm_queue

`default_nettype wire

FILE: hdl/qdnm_back.sv
// Back part: rounds and clips the level, dequantizes it and keeps the group map.
`timescale 1ns / 1ps
`default_nettype none

module qdnm_back
#(
    parameter int COEFF_WIDTH = 16,
    parameter int MAX_GROUPS  = 64
)
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire qdnm_pkg::cfg_regs_t cfg,
    input  wire logic                item_valid,
    output logic                     item_stall,
    input  wire qdnm_pkg::fb_item_t  item_data,
    output logic                     res_valid,
    input  wire logic                res_stall,
    output qdnm_pkg::res_beat_t      res_data
);
    import qdnm_pkg::*;

    localparam int CW     = COEFF_WIDTH;
    localparam int DPROD_W = CW + SCALE_W + 1;
    localparam int RSUM_W  = ((DPROD_W > ROUND_W) ? DPROD_W : ROUND_W) + 1;
    localparam logic [QSUM_W-1:0] QLIM = QSUM_W'(1) << (CW - 1);
    localparam logic signed [RSUM_W-1:0] REC_HI =
        signed'((RSUM_W'(1) << (CW - 1)) - RSUM_W'(1));
    localparam logic signed [RSUM_W-1:0] REC_LO = -REC_HI - RSUM_W'(1);
    localparam logic [MAP_W-1:0] MAP_MASK = {MAP_W{1'b1}} >> (MAP_W - MAX_GROUPS);

    // Side information that rides along with each level.
    typedef struct packed {
        logic              group_nonzero;
        logic              group_done;
        logic              block_done;
        logic [MAP_W-1:0]  nonzero_map;
    } side_t;

    logic                       a_valid_reg;
    logic                       b_valid_reg;
    logic                       c_valid_reg;
    logic                       a_en;
    logic                       b_en;
    logic                       c_en;
    logic signed [CW-1:0]       a_level_reg;
    side_t                      a_side_reg;
    logic signed [CW-1:0]       b_level_reg;
    logic signed [DPROD_W-1:0]  b_prod_reg;
    side_t                      b_side_reg;
    res_beat_t                  c_res_reg;

    logic [QSUM_W-1:0]          qsum;
    logic [QSUM_W-1:0]          qmag;
    logic [QSUM_W-1:0]          qclip;
    logic [CW-1:0]              level_mag;
    logic signed [CW-1:0]       level;
    logic                       any_reg;
    logic                       any_next;
    logic [MAP_W-1:0]           map_reg;
    logic [MAP_W-1:0]           map_next;
    logic                       any_now;
    side_t                      side;

    logic signed [RSUM_W-1:0]   rsum;
    logic signed [RSUM_W-1:0]   rshift;
    logic signed [RSUM_W-1:0]   rclip;
    logic signed [CW+COEF_W-1:0] level_ext;

    // Stage enables: a stage moves when it is empty or its beat moves on.
    assign c_en       = !c_valid_reg || !res_stall;
    assign b_en       = !b_valid_reg || c_en;
    assign a_en       = !a_valid_reg || b_en;
    assign item_stall = !a_en;

    // Forward rounding, shift and saturation to the coefficient range.
    assign qsum      = QSUM_W'(item_data.prod) + QSUM_W'(cfg.quant_round);
    assign qmag      = qsum >> cfg.quant_shift;
    always_comb
    begin
        qclip = qmag;
        if (item_data.neg)
        begin
            if (qmag > QLIM)
            begin
                qclip = QLIM;
            end
        end
        else if (qmag > (QLIM - QSUM_W'(1)))
        begin
            qclip = QLIM - QSUM_W'(1);
        end
    end
    assign level_mag = qclip[CW-1:0];
    assign level     = item_data.neg ? signed'(~level_mag + CW'(1)) : signed'(level_mag);

    // Group flag and map update, done in stream order as items leave the queue.
    always_comb
    begin
        any_now            = any_reg || (level != '0);
        any_next           = any_now;
        map_next           = map_reg;
        side.group_nonzero = 1'b0;
        side.group_done    = item_data.group_end;
        side.block_done    = item_data.block_end;
        side.nonzero_map   = '0;
        if (item_data.group_end)
        begin
            side.group_nonzero = any_now;
            map_next           = ((map_reg << 1) | MAP_W'(any_now)) & MAP_MASK;
            any_next           = 1'b0;
        end
        if (item_data.block_end)
        begin
            side.nonzero_map = map_next & MAP_MASK;
            map_next         = '0;
            any_next         = 1'b0;
        end
    end

    // Inverse rounding, floor shift and saturation.
    assign rsum   = RSUM_W'(b_prod_reg) + signed'(RSUM_W'(cfg.dequant_round));
    assign rshift = rsum >>> cfg.dequant_shift;
    always_comb
    begin
        rclip = rshift;
        if (rshift > REC_HI)
        begin
            rclip = REC_HI;
        end
        else if (rshift < REC_LO)
        begin
            rclip = REC_LO;
        end
    end
    assign level_ext = (CW + COEF_W)'(b_level_reg);

    // Valid bits and carried state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
            any_reg     <= 1'b0;
            map_reg     <= '0;
        end
        else
        begin
            if (a_en)
            begin
                a_valid_reg <= item_valid;
            end
            if (b_en)
            begin
                b_valid_reg <= a_valid_reg;
            end
            if (c_en)
            begin
                c_valid_reg <= b_valid_reg;
            end
            if (a_en && item_valid)
            begin
                any_reg <= any_next;
                map_reg <= map_next;
            end
        end
    end

    // Level stage, dequantizing product stage and result register.
    always_ff @(posedge clk)
    begin
        if (a_en && item_valid)
        begin
            a_level_reg <= level;
            a_side_reg  <= side;
        end
        if (b_en && a_valid_reg)
        begin
            b_level_reg <= a_level_reg;
            b_prod_reg  <= DPROD_W'(a_level_reg) * signed'({1'b0, cfg.dequant_scale});
            b_side_reg  <= a_side_reg;
        end
        if (c_en && b_valid_reg)
        begin
            c_res_reg.level         <= level_ext[COEF_W-1:0];
            c_res_reg.recon         <= rclip[COEF_W-1:0];
            c_res_reg.group_nonzero <= b_side_reg.group_nonzero;
            c_res_reg.group_done    <= b_side_reg.group_done;
            c_res_reg.block_done    <= b_side_reg.block_done;
            c_res_reg.nonzero_map   <= b_side_reg.nonzero_map;
        end
    end

    assign res_valid = c_valid_reg;
    assign res_data  = c_res_reg;

endmodule : qdnm_back

`default_nettype wire

FILE: hdl/quant_dequant_nonzero_map.sv
// Top level: configuration registers, front part, queue and back part.
//
// Quantizes each transform coefficient as (|c| * quant_scale + quant_round)
// >> quant_shift with the sign restored, dequantizes the level as
// (level * dequant_scale + dequant_round) >>> dequant_shift, and saturates both
// to the COEFF_WIDTH-bit signed range. A per-group nonzero flag is shifted
// into a MAX_GROUPS-bit map that is given with the block_end beat and then
// cleared. The block takes one coefficient per clock while it does not stall
// its input, and gives one result beat per coefficient; each beat passes the
// forward multiplier register, the queue, the level register, the
// dequantizing multiplier register and the result register. The four-entry
// queue lets the front keep taking beats while the output stalls.
// Configuration writes are taken at any time but must only be made while
// the block is idle.
`timescale 1ns / 1ps
`default_nettype none

module quant_dequant_nonzero_map
#(
    parameter int COEFF_WIDTH = 16,
    parameter int MAX_GROUPS  = 64
)
(
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           cfg_we,
    input  wire logic [qdnm_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [qdnm_pkg::CFG_DATA_W-1:0] cfg_data,
    input  wire logic                           coef_valid,
    output logic                                coef_stall,
    input  wire qdnm_pkg::coef_beat_t           coef_data,
    output logic                                res_valid,
    input  wire logic                           res_stall,
    output qdnm_pkg::res_beat_t                 res_data
);
    import qdnm_pkg::*;

    cfg_regs_t cfg_reg;
    logic      fq_valid;
    logic      fq_stall;
    fb_item_t  fq_data;
    logic      qb_valid;
    logic      qb_stall;
    fb_item_t  qb_data;

    // Configuration registers; writes to unknown indexes are dropped.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_QUANT_SCALE:   cfg_reg.quant_scale   <= cfg_data[SCALE_W-1:0];
                CFG_QUANT_ROUND:   cfg_reg.quant_round   <= cfg_data[ROUND_W-1:0];
                CFG_QUANT_SHIFT:   cfg_reg.quant_shift   <= cfg_data[SHIFT_W-1:0];
                CFG_DEQUANT_SCALE: cfg_reg.dequant_scale <= cfg_data[SCALE_W-1:0];
                CFG_DEQUANT_ROUND: cfg_reg.dequant_round <= cfg_data[ROUND_W-1:0];
                CFG_DEQUANT_SHIFT: cfg_reg.dequant_shift <= cfg_data[SHIFT_W-1:0];
                default:           cfg_reg               <= cfg_reg;
            endcase
        end
    end

    qdnm_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .coef_valid (coef_valid),
        .coef_stall (coef_stall),
        .coef_data  (coef_data),
        .item_valid (fq_valid),
        .item_stall (fq_stall),
        .item_data  (fq_data)
    );

    qdnm_queue u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (fq_valid),
        .push_stall (fq_stall),
        .push_data  (fq_data),
        .pop_valid  (qb_valid),
        .pop_stall  (qb_stall),
        .pop_data   (qb_data)
    );

    qdnm_back
    #(
        .COEFF_WIDTH (COEFF_WIDTH),
        .MAX_GROUPS  (MAX_GROUPS)
    )
    u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .item_valid (qb_valid),
        .item_stall (qb_stall),
        .item_data  (qb_data),
        .res_valid  (res_valid),
        .res_stall  (res_stall),
        .res_data   (res_data)
    );

endmodule : quant_dequant_nonzero_map

`default_nettype wire

FILE: tb/tb_quant_dequant_nonzero_map.sv
// Self-checking testbench for the quantize / dequantize block with its per-group nonzero map.
`timescale 1ns / 1ps

module tb_quant_dequant_nonzero_map;

    import qdnm_pkg::*;

    // Saturation bounds of a level or a reconstructed coefficient.
    localparam longint LVL_MAX = 32767;
    localparam longint LVL_MIN = -32768;

    // Register indexes past the last register; writes to them must be ignored.
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;

    // Idling percentages per phase.
    localparam int unsigned IDLE_HEAVY = 76;
    localparam int unsigned IDLE_LIGHT = 11;

    // Beats per random phase and the long receiver hold-off.
    localparam int unsigned PHASE_BEATS = 200;
    localparam int unsigned HOLD_LEN    = 300;

    // One row of the directed stimulus.
    typedef struct {
        int unsigned setting;
        coef_beat_t  beat;
        bit          typed;
        res_beat_t   want;
    } stim_row_t;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                  coef_valid;
    logic                  coef_stall;
    coef_beat_t            coef_data;
    logic                  res_valid;
    logic                  res_stall;
    res_beat_t             res_data;

    // Predictor state: register copy, open group flag and the group map.
    cfg_regs_t             qcfg;
    logic                  open_group_nz;
    logic [MAP_W-1:0]      group_flags;

    res_beat_t             pending_results[$];
    stim_row_t             stim_rows[$];
    cfg_regs_t             dir_cfg[5];
    int unsigned           err_count;
    int unsigned           beats_sent;
    int unsigned           send_idle_pct;
    int unsigned           recv_stall_pct;
    int unsigned           hold_cycles;
    res_beat_t             got_want;

    quant_dequant_nonzero_map dut
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .coef_valid (coef_valid),
        .coef_stall (coef_stall),
        .coef_data  (coef_data),
        .res_valid  (res_valid),
        .res_stall  (res_stall),
        .res_data   (res_data)
    );

    always #5 clk = ~clk;

    // Print one line per mismatch and keep count.
    task automatic report_mismatch(input string msg);
        err_count++;
        $display("[%0t] mismatch: %s", $realtime, msg);
    endtask

    task automatic check_field(input string name, input logic [63:0] got,
                               input logic [63:0] want);
        if (got !== want)
        begin
            report_mismatch($sformatf("%s got %0h want %0h", name, got, want));
        end
    endtask

    // Quantize, dequantize and update the group state for one accepted beat.
    function automatic res_beat_t quantize_beat(input coef_beat_t b);
        longint          c;
        longint          lvl;
        longint          rec;
        longint          dsc;
        longint          drd;
        longint unsigned mag;
        longint unsigned qmag;
        longint unsigned qsc;
        longint unsigned qrd;
        res_beat_t       r;
        c    = longint'($signed(b.coefficient));
        mag  = (c < 0) ? -c : c;
        qsc  = qcfg.quant_scale;
        qrd  = qcfg.quant_round;
        qmag = (mag * qsc + qrd) >> qcfg.quant_shift;
        if (c < 0)
        begin
            lvl = (qmag > 64'd32768) ? LVL_MIN : -longint'(qmag);
        end
        else
        begin
            lvl = (qmag > 64'd32767) ? LVL_MAX : longint'(qmag);
        end
        // Dequantize wide; the arithmetic shift rounds toward minus infinity.
        dsc = qcfg.dequant_scale;
        drd = qcfg.dequant_round;
        rec = (lvl * dsc + drd) >>> qcfg.dequant_shift;
        if (rec > LVL_MAX)
        begin
            rec = LVL_MAX;
        end
        else if (rec < LVL_MIN)
        begin
            rec = LVL_MIN;
        end
        r            = '0;
        r.level      = lvl[15:0];
        r.recon      = rec[15:0];
        r.group_done = b.group_end;
        r.block_done = b.block_end;
        if (lvl != 0)
        begin
            open_group_nz = 1'b1;
        end
        // Group end shifts the flag in before a block end hands the map out.
        if (b.group_end)
        begin
            r.group_nonzero = open_group_nz;
            group_flags     = {group_flags[MAP_W-2:0], open_group_nz};
            open_group_nz   = 1'b0;
        end
        if (b.block_end)
        begin
            r.nonzero_map = group_flags;
            group_flags   = '0;
            open_group_nz = 1'b0;
        end
        return r;
    endfunction

    // Offer one beat after a random gap and record its expected result.
    task automatic send_beat(input coef_beat_t b, input bit typed, input res_beat_t want);
        res_beat_t predicted;
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            coef_valid <= 1'b0;
            @(posedge clk);
        end
        coef_valid <= 1'b1;
        coef_data  <= b;
        do
        begin
            @(posedge clk);
        end
        while (coef_stall !== 1'b0);
        predicted = quantize_beat(b);
        pending_results.push_back(typed ? want : predicted);
        beats_sent++;
    endtask

    // Write one register; the caller lowers the write enable afterwards.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        case (idx)
            CFG_QUANT_SCALE:   qcfg.quant_scale   = data[SCALE_W-1:0];
            CFG_QUANT_ROUND:   qcfg.quant_round   = data[ROUND_W-1:0];
            CFG_QUANT_SHIFT:   qcfg.quant_shift   = data[SHIFT_W-1:0];
            CFG_DEQUANT_SCALE: qcfg.dequant_scale = data[SCALE_W-1:0];
            CFG_DEQUANT_ROUND: qcfg.dequant_round = data[ROUND_W-1:0];
            CFG_DEQUANT_SHIFT: qcfg.dequant_shift = data[SHIFT_W-1:0];
            default:           ;
        endcase
        @(posedge clk);
    endtask

    task automatic apply_settings(input cfg_regs_t s, input bit with_spares);
        write_reg(CFG_QUANT_SCALE, CFG_DATA_W'(s.quant_scale));
        write_reg(CFG_QUANT_ROUND, CFG_DATA_W'(s.quant_round));
        write_reg(CFG_QUANT_SHIFT, CFG_DATA_W'(s.quant_shift));
        write_reg(CFG_DEQUANT_SCALE, CFG_DATA_W'(s.dequant_scale));
        write_reg(CFG_DEQUANT_ROUND, CFG_DATA_W'(s.dequant_round));
        write_reg(CFG_DEQUANT_SHIFT, CFG_DATA_W'(s.dequant_shift));
        if (with_spares)
        begin
            write_reg(CFG_SPARE_LO, '1);
            write_reg(CFG_SPARE_HI, '1);
        end
        cfg_we <= 1'b0;
    endtask

    // Stop offering beats and let every result drain.
    task automatic drain();
        int unsigned waited;
        coef_valid <= 1'b0;
        waited = 0;
        while (pending_results.size() != 0 && waited < 20000)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (10) @(posedge clk);
    endtask

    function automatic cfg_regs_t make_cfg(input int unsigned qs, input int unsigned qr,
                                           input int unsigned qsh, input int unsigned ds,
                                           input int unsigned dr, input int unsigned dsh);
        cfg_regs_t s;
        s.quant_scale   = SCALE_W'(qs);
        s.quant_round   = ROUND_W'(qr);
        s.quant_shift   = SHIFT_W'(qsh);
        s.dequant_scale = SCALE_W'(ds);
        s.dequant_round = ROUND_W'(dr);
        s.dequant_shift = SHIFT_W'(dsh);
        return s;
    endfunction

    // Zero, maximum, or a typical value, so that extremes recur in random phases.
    function automatic int unsigned pick_value(input int unsigned maxv, input int unsigned typical);
        int unsigned sel;
        sel = $urandom_range(0, 7);
        if (sel == 0)
        begin
            return 0;
        end
        else if (sel == 1)
        begin
            return maxv;
        end
        return typical;
    endfunction

    task automatic add_row(input int unsigned setting, input int coef, input bit gend,
                           input bit bend, input bit typed, input int lvl, input int rec,
                           input bit gnz, input longint unsigned map);
        stim_row_t row;
        row.setting               = setting;
        row.beat.coefficient      = COEF_W'(coef);
        row.beat.group_end        = gend;
        row.beat.block_end        = bend;
        row.typed                 = typed;
        row.want.level            = COEF_W'(lvl);
        row.want.recon            = COEF_W'(rec);
        row.want.group_nonzero    = gnz;
        row.want.group_done       = gend;
        row.want.block_done       = bend;
        row.want.nonzero_map      = map;
        stim_rows.push_back(row);
    endtask

    // One transform block: groups of random size, sometimes more groups than
    // the map holds, sometimes ending without a group end, with some noise.
    task automatic send_random_block();
        int unsigned n_groups;
        int unsigned gsize;
        bit          long_run;
        bit          cut_short;
        coef_beat_t  b;
        long_run  = ($urandom_range(0, 9) == 0);
        n_groups  = long_run ? $urandom_range(60, 72) : $urandom_range(1, 8);
        cut_short = ($urandom_range(0, 7) == 0);
        for (int unsigned g = 0; g < n_groups + cut_short; g++)
        begin
            if (long_run)
            begin
                gsize = $urandom_range(1, 2);
            end
            else
            begin
                gsize = ($urandom_range(0, 3) == 0) ? $urandom_range(5, 16) : $urandom_range(1, 4);
            end
            for (int unsigned k = 0; k < gsize; k++)
            begin
                case ($urandom_range(0, 9))
                    0, 1, 2, 3: b.coefficient = '0;
                    4, 5, 6:    b.coefficient = COEF_W'($urandom_range(0, 40)) - 16'd20;
                    default:    b.coefficient = COEF_W'($urandom);
                endcase
                b.group_end = (k == gsize - 1) && (g < n_groups);
                b.block_end = (k == gsize - 1) && (g == n_groups + cut_short - 1);
                if ($urandom_range(0, 19) == 0)
                begin
                    b.group_end = $urandom_range(0, 1);
                    b.block_end = ($urandom_range(0, 3) == 0);
                end
                send_beat(b, 1'b0, '0);
            end
        end
    endtask

    // Receiver: random stall, or a long hold-off when one is requested.
    initial
    begin
        res_stall = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_cycles != 0)
            begin
                res_stall   <= 1'b1;
                hold_cycles = hold_cycles - 1;
            end
            else
            begin
                res_stall <= ($urandom_range(0, 99) < recv_stall_pct);
            end
        end
    end

    // Compare every accepted result beat with the oldest expectation.
    always @(posedge clk)
    begin
        if (rst_n === 1'b1 && res_valid === 1'b1 && res_stall === 1'b0)
        begin
            if (pending_results.size() == 0)
            begin
                report_mismatch("result beat with nothing expected");
            end
            else
            begin
                got_want = pending_results.pop_front();
                check_field("level", 64'(res_data.level), 64'(got_want.level));
                check_field("recon", 64'(res_data.recon), 64'(got_want.recon));
                check_field("group_nonzero", 64'(res_data.group_nonzero),
                            64'(got_want.group_nonzero));
                check_field("group_done", 64'(res_data.group_done), 64'(got_want.group_done));
                check_field("block_done", 64'(res_data.block_done), 64'(got_want.block_done));
                check_field("nonzero_map", res_data.nonzero_map, got_want.nonzero_map);
            end
        end
    end

    // Run limit, far above the slowest legal run.
    initial
    begin
        #5000000;
        $display("TEST FAILED");
        $finish;
    end

    initial
    begin
        int unsigned cur_setting;
        int unsigned seg_start;
        cfg_regs_t   s;
        rst_n          = 1'b0;
        cfg_we         = 1'b0;
        cfg_index      = '0;
        cfg_data       = '0;
        coef_valid     = 1'b0;
        coef_data      = '0;
        err_count      = 0;
        beats_sent     = 0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_cycles    = 0;
        qcfg           = '0;
        open_group_nz  = 1'b0;
        group_flags    = '0;

        // Directed settings: reset values, identity, all maxima, saturating
        // shift of zero, and a negative floor shift.
        dir_cfg[0] = make_cfg(0, 0, 0, 0, 0, 0);
        dir_cfg[1] = make_cfg(1, 0, 0, 1, 0, 0);
        dir_cfg[2] = make_cfg(65535, 30'h3FFFFFFF, 31, 65535, 30'h3FFFFFFF, 31);
        dir_cfg[3] = make_cfg(65535, 30'h3FFFFFFF, 0, 65535, 30'h3FFFFFFF, 0);
        dir_cfg[4] = make_cfg(1, 0, 0, 3, 0, 1);

        // After reset every level and recon is zero.
        add_row(0, 32767, 0, 0, 1, 0, 0, 0, 0);
        add_row(0, -32768, 1, 0, 1, 0, 0, 0, 0);
        add_row(0, 1, 0, 1, 1, 0, 0, 0, 0);
        add_row(0, -1, 1, 1, 1, 0, 0, 0, 0);
        // Identity scaling: extremes pass through, map reads 101.
        add_row(1, 32767, 1, 0, 1, 32767, 32767, 1, 0);
        add_row(1, 0, 1, 0, 1, 0, 0, 0, 0);
        add_row(1, -32768, 1, 1, 1, -32768, -32768, 1, 64'd5);
        // Block end without group end drops the open flag.
        add_row(1, 5, 0, 0, 1, 5, 5, 0, 0);
        add_row(1, 0, 0, 1, 1, 0, 0, 0, 0);
        add_row(1, 0, 1, 1, 1, 0, 0, 0, 0);
        add_row(1, -7, 1, 0, 1, -7, -7, 1, 0);
        add_row(1, 3, 1, 1, 1, 3, 3, 1, 64'd3);
        // All registers at their maxima.
        add_row(2, 32767, 0, 0, 0, 0, 0, 0, 0);
        add_row(2, -32768, 1, 0, 0, 0, 0, 0, 0);
        add_row(2, 0, 0, 0, 0, 0, 0, 0, 0);
        add_row(2, -1, 1, 1, 0, 0, 0, 0, 0);
        // Saturation of both level and recon.
        add_row(3, 32767, 0, 0, 0, 0, 0, 0, 0);
        add_row(3, -32768, 0, 0, 0, 0, 0, 0, 0);
        add_row(3, 0, 1, 0, 0, 0, 0, 0, 0);
        add_row(3, -2, 0, 1, 0, 0, 0, 0, 0);
        add_row(3, 100, 1, 1, 0, 0, 0, 0, 0);
        // Floor shift of negative products.
        add_row(4, -1, 0, 0, 0, 0, 0, 0, 0);
        add_row(4, -5, 1, 1, 0, 0, 0, 0, 0);
        add_row(4, 1, 1, 1, 0, 0, 0, 0, 0);

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part.
        cur_setting = 0;
        foreach (stim_rows[i])
        begin
            if (stim_rows[i].setting != cur_setting)
            begin
                drain();
                cur_setting = stim_rows[i].setting;
                apply_settings(dir_cfg[cur_setting], cur_setting == 1);
            end
            send_beat(stim_rows[i].beat, stim_rows[i].typed, stim_rows[i].want);
        end

        // Random phases, each with fresh settings and its own idling.
        for (int unsigned seg = 0; seg < 8; seg++)
        begin
            drain();
            s = make_cfg(pick_value(65535, $urandom_range(1, 65535)),
                         pick_value(30'h3FFFFFFF, $urandom_range(0, 16384)),
                         pick_value(31, $urandom_range(6, 20)),
                         pick_value(65535, $urandom_range(0, 4000)),
                         pick_value(30'h3FFFFFFF, $urandom_range(0, 255)),
                         pick_value(31, $urandom_range(0, 8)));
            apply_settings(s, 1'b0);
            case (seg % 4)
                0:
                begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                end
                1:
                begin
                    send_idle_pct  = IDLE_HEAVY;
                    recv_stall_pct = 0;
                end
                2:
                begin
                    send_idle_pct  = 0;
                    recv_stall_pct = IDLE_HEAVY;
                end
                default:
                begin
                    send_idle_pct  = IDLE_LIGHT;
                    recv_stall_pct = IDLE_LIGHT;
                end
            endcase
            // One long hold-off fills the block so that it stalls its input.
            if (seg == 4)
            begin
                hold_cycles = HOLD_LEN;
            end
            seg_start = beats_sent;
            while (beats_sent - seg_start < PHASE_BEATS)
            begin
                send_random_block();
            end
        end

        drain();
        if (pending_results.size() != 0)
        begin
            report_mismatch($sformatf("%0d result beats never arrived",
                                      pending_results.size()));
        end
        if (err_count == 0)
        begin
            $display("TEST PASSED");
        end
        else
        begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
